// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the playout delay core.
// Users must have clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_CLK(lbl, !(expr), msg)
`endif

// ===== rtl/core/apdc_pkg.sv =====
// Shared types and constants of the adaptive playout delay core.
// No dependencies.
package apdc_pkg;

  localparam int unsigned CAPACITY_FRAMES_DEF = 64;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 17;

  localparam int unsigned FrameW     = 32;
  localparam int unsigned AvgW       = 24;
  localparam int unsigned FramesOutW = 6;
  localparam int unsigned MeasW      = 16;
  localparam int unsigned DilW       = 16;

  localparam int unsigned MulAW = 25;
  localparam int unsigned MulBW = 18;
  localparam int unsigned ProdW = MulAW + MulBW;

  localparam logic [16:0]     SmoothOne = 17'd65536;
  localparam logic [DilW-1:0] DilOne    = 16'd4096;

  typedef struct packed {
    logic [16:0] smoothing;
    logic [15:0] jitter_multiplier;
    logic [5:0]  min_frames;
    logic [12:0] dilation_min;
    logic [15:0] dilation_max;
    logic [15:0] dilation_gain;
    logic        auto_enable;
    logic [5:0]  start_frames;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    smoothing:         17'd6554,
    jitter_multiplier: 16'd512,
    min_frames:        6'd0,
    dilation_min:      13'd3686,
    dilation_max:      16'd4506,
    dilation_gain:     16'd0,
    auto_enable:       1'b1,
    start_frames:      6'd2
  };

  typedef enum logic [CfgIdxW-1:0] {
    REG_SMOOTHING    = 3'd0,
    REG_JITTER_MULT  = 3'd1,
    REG_MIN_FRAMES   = 3'd2,
    REG_DIL_MIN      = 3'd3,
    REG_DIL_MAX      = 3'd4,
    REG_DIL_GAIN     = 3'd5,
    REG_AUTO_ENABLE  = 3'd6,
    REG_START_FRAMES = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAT,
    ST_JIT,
    ST_JUPD,
    ST_WANT,
    ST_TGT,
    ST_DIL,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    MUL_LAT,
    MUL_JIT,
    MUL_WANT,
    MUL_DIL
  } mul_op_e;

  typedef struct packed {
    logic    load;
    logic    mul_en;
    mul_op_e mul_op;
    logic    lat_wr;
    logic    jit_wr;
    logic    meas_wr;
    logic    tgt_wr;
    logic    commit;
  } cmd_t;

  typedef struct packed {
    logic first;
  } status_t;

endpackage

// ===== rtl/core/apdc_if.sv =====
// Item channels of the adaptive playout delay core: packet in, result out.
// Depends on apdc_pkg.
interface apdc_in_if;
  import apdc_pkg::*;
  logic              valid;
  logic              ready;
  logic [FrameW-1:0] sender_stamp;
  logic [FrameW-1:0] arrival_frame;
  logic [FrameW-1:0] play_frame;
  logic              buffered_present;

  modport source (
    output valid, sender_stamp, arrival_frame, play_frame, buffered_present,
    input  ready
  );
  modport sink (
    input  valid, sender_stamp, arrival_frame, play_frame, buffered_present,
    output ready
  );
endinterface

interface apdc_out_if;
  import apdc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [AvgW-1:0]       latency_out;
  logic [AvgW-1:0]       jitter_out;
  logic [FramesOutW-1:0] target_frames;
  logic [MeasW-1:0]      measured_frames;
  logic [FramesOutW-1:0] current_frames;
  logic [DilW-1:0]       rate_factor;

  modport source (
    output valid, latency_out, jitter_out, target_frames, measured_frames,
           current_frames, rate_factor,
    input  ready
  );
  modport sink (
    input  valid, latency_out, jitter_out, target_frames, measured_frames,
           current_frames, rate_factor,
    output ready
  );
endinterface

// ===== rtl/core/apdc_cfg.sv =====
// Configuration register bank of the playout delay core.
// Depends on apdc_pkg.
module apdc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [apdc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [apdc_pkg::CfgDataW-1:0] cfg_wdata_i,
  output apdc_pkg::cfg_t                cfg_o
);
  import apdc_pkg::*;

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_SMOOTHING:    cfg_d.smoothing         = cfg_wdata_i[16:0];
        REG_JITTER_MULT:  cfg_d.jitter_multiplier = cfg_wdata_i[15:0];
        REG_MIN_FRAMES:   cfg_d.min_frames        = cfg_wdata_i[5:0];
        REG_DIL_MIN:      cfg_d.dilation_min      = cfg_wdata_i[12:0];
        REG_DIL_MAX:      cfg_d.dilation_max      = cfg_wdata_i[15:0];
        REG_DIL_GAIN:     cfg_d.dilation_gain     = cfg_wdata_i[15:0];
        REG_AUTO_ENABLE:  cfg_d.auto_enable       = cfg_wdata_i[0];
        REG_START_FRAMES: cfg_d.start_frames      = cfg_wdata_i[5:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/apdc_ctrl.sv =====
// Sequencer of the playout delay core: handshakes and datapath commands.
// Depends on apdc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module apdc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  apdc_pkg::status_t status_i,
  output apdc_pkg::cmd_t    cmd_o
);
  import apdc_pkg::*;

  state_e state_d, state_q;
  logic   out_valid_d, out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.first ? ST_WANT : ST_LAT;
        end
      end
      ST_LAT:  state_d = ST_JIT;
      ST_JIT:  state_d = ST_JUPD;
      ST_JUPD: state_d = ST_WANT;
      ST_WANT: state_d = ST_TGT;
      ST_TGT:  state_d = ST_DIL;
      ST_DIL:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o.load     = 1'b0;
    cmd_o.mul_en   = 1'b0;
    cmd_o.mul_op   = MUL_LAT;
    cmd_o.lat_wr   = 1'b0;
    cmd_o.jit_wr   = 1'b0;
    cmd_o.meas_wr  = 1'b0;
    cmd_o.tgt_wr   = 1'b0;
    cmd_o.commit   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_LAT: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_LAT;
      end
      ST_JIT: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_JIT;
        cmd_o.lat_wr = 1'b1;
      end
      ST_JUPD: begin
        cmd_o.jit_wr = 1'b1;
      end
      ST_WANT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_op  = MUL_WANT;
        cmd_o.meas_wr = 1'b1;
      end
      ST_TGT: begin
        cmd_o.tgt_wr = 1'b1;
      end
      ST_DIL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_DIL;
      end
      ST_DONE: begin
        cmd_o.commit = out_free;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `ASSERT_CLK(a_accept_leaves_idle, (in_valid_i && in_ready_o) |=> (state_q != ST_IDLE), "accepted item left controller idle")
  `ASSERT_CLK(a_commit_sets_valid, cmd_o.commit |=> out_valid_q, "committed result not presented")
  `ASSERT_NEVER(a_no_accept_on_commit, in_ready_o && cmd_o.commit, "accept and commit in one cycle")
  `ASSERT_CLK(a_done_waits, (state_q == ST_DONE && out_valid_q && !out_ready_i) |=> (state_q == ST_DONE), "result overwritten while stalled")

endmodule

// ===== rtl/core/apdc_dp.sv =====
// Datapath of the playout delay core: averages, shared multiplier, target,
// dilation, depth step and result register. Depends on apdc_pkg.
module apdc_dp #(
  parameter int unsigned CAPACITY_FRAMES = apdc_pkg::CAPACITY_FRAMES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  apdc_pkg::cmd_t                    cmd_i,
  output apdc_pkg::status_t                 status_o,
  input  apdc_pkg::cfg_t                    cfg_i,
  input  logic [apdc_pkg::FrameW-1:0]       sender_stamp_i,
  input  logic [apdc_pkg::FrameW-1:0]       arrival_frame_i,
  input  logic [apdc_pkg::FrameW-1:0]       play_frame_i,
  input  logic                              buffered_present_i,
  output logic [apdc_pkg::AvgW-1:0]         latency_out_o,
  output logic [apdc_pkg::AvgW-1:0]         jitter_out_o,
  output logic [apdc_pkg::FramesOutW-1:0]   target_frames_o,
  output logic [apdc_pkg::MeasW-1:0]        measured_frames_o,
  output logic [apdc_pkg::FramesOutW-1:0]   current_frames_o,
  output logic [apdc_pkg::DilW-1:0]         rate_factor_o
);
  import apdc_pkg::*;

  localparam int unsigned DepthW = $clog2(CAPACITY_FRAMES);
  localparam int unsigned MaxD   = CAPACITY_FRAMES - 1;
  localparam logic [DepthW-1:0] MaxDepth = DepthW'(MaxD);

  // sequence state
  logic              have_sample_q;
  logic [AvgW-1:0]   lat_q, jit_q;
  logic [DepthW-1:0] depth_q;

  // per-item working registers
  logic [FrameW-1:0]       server_q, applied_q, meas_q;
  logic                    buffered_q;
  logic [AvgW-1:0]         samp_q;
  logic [DepthW-1:0]       cur_q, target_q;
  logic signed [ProdW-1:0] prod_q;

  // result register
  logic [AvgW-1:0]       lat_out_q, jit_out_q;
  logic [FramesOutW-1:0] tgt_out_q, cur_out_q;
  logic [MeasW-1:0]      meas_out_q;
  logic [DilW-1:0]       dil_out_q;

  logic [DepthW-1:0]       start_clamped, cur_in, cur_next;
  logic [FrameW:0]         rx_diff;
  logic [AvgW-1:0]         sample_in, dev;
  logic [FrameW-1:0]       applied_in, meas_d;
  logic [16:0]             s_eff;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod_d;
  logic [43:0]             lat_acc, jit_acc;
  logic [41:0]             want_sum;
  logic [25:0]             tgt_raw, tgt_lo;
  logic [DepthW-1:0]       tgt_d;
  logic signed [33:0]      err_full;
  logic signed [17:0]      err;
  logic signed [47:0]      dil_x, dil_lo, dmin_s, dmax_s;
  logic [DilW-1:0]         dil_d;
  logic                    adapt;

  assign status_o.first = !have_sample_q;

  // item intake
  assign start_clamped = (16'(cfg_i.start_frames) > 16'(MaxD)) ? MaxDepth
                                                                : DepthW'(cfg_i.start_frames);
  assign cur_in  = have_sample_q ? depth_q : start_clamped;
  assign rx_diff = {1'b0, arrival_frame_i} - {1'b0, sender_stamp_i};

  always_comb begin
    if (rx_diff[FrameW]) begin
      sample_in = '0;
    end else if (|rx_diff[31:16]) begin
      sample_in = '1;
    end else begin
      sample_in = {rx_diff[15:0], 8'h00};
    end
  end

  assign applied_in = (play_frame_i >= 32'(cur_in)) ? play_frame_i - 32'(cur_in)
                                                    : '0;
  assign meas_d = (server_q >= applied_q) ? server_q - applied_q : '0;

  // shared multiplier
  assign s_eff = (cfg_i.smoothing > SmoothOne) ? SmoothOne : cfg_i.smoothing;
  assign dev   = (samp_q >= lat_q) ? samp_q - lat_q : lat_q - samp_q;

  assign err_full = $signed({2'b00, meas_q}) - $signed({{(34 - DepthW){1'b0}}, target_q});
  // errors past 16 bits already drive the dilation to a limit
  assign err      = (err_full > 34'sd65535) ? 18'sd65535 : err_full[17:0];

  always_comb begin
    unique case (cmd_i.mul_op)
      MUL_LAT: begin
        mul_a = $signed({1'b0, samp_q}) - $signed({1'b0, lat_q});
        mul_b = $signed({1'b0, s_eff});
      end
      MUL_JIT: begin
        mul_a = $signed({1'b0, dev}) - $signed({1'b0, jit_q});
        mul_b = $signed({1'b0, s_eff});
      end
      MUL_WANT: begin
        mul_a = $signed({1'b0, jit_q});
        mul_b = $signed({2'b00, cfg_i.jitter_multiplier});
      end
      MUL_DIL: begin
        mul_a = $signed({{(MulAW - 18){err[17]}}, err});
        mul_b = $signed({2'b00, cfg_i.dilation_gain});
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // avg + (x - avg) * s, rounded
  assign lat_acc = {4'b0, lat_q, 16'b0} + {prod_q[ProdW-1], prod_q} + 44'd32768;
  assign jit_acc = {4'b0, jit_q, 16'b0} + {prod_q[ProdW-1], prod_q} + 44'd32768;

  // target depth, ceiling of Q.16
  assign want_sum = {10'b0, lat_q, 8'b0} + {2'b00, prod_q[39:0]} + 42'h0FFFF;
  assign tgt_raw  = want_sum[41:16];
  assign tgt_lo   = (tgt_raw < 26'(cfg_i.min_frames)) ? 26'(cfg_i.min_frames) : tgt_raw;
  assign tgt_d    = (tgt_lo > 26'(MaxD)) ? MaxDepth : DepthW'(tgt_lo);

  // dilation
  assign dil_x  = $signed({prod_q[ProdW-1], prod_q, 4'b0}) + 48'sd4096;
  assign dmin_s = $signed({35'b0, cfg_i.dilation_min});
  assign dmax_s = $signed({32'b0, cfg_i.dilation_max});
  assign dil_lo = (dil_x < dmin_s) ? dmin_s : dil_x;

  assign adapt = cfg_i.auto_enable && buffered_q;

  always_comb begin
    cur_next = cur_q;
    dil_d    = DilOne;
    if (adapt) begin
      dil_d = (dil_lo > dmax_s) ? cfg_i.dilation_max : dil_lo[DilW-1:0];
      if (cur_q < target_q && meas_q >= 32'(cur_q)) begin
        cur_next = cur_q + DepthW'(1);
      end else if (cur_q > target_q && meas_q <= 32'(cur_q)) begin
        cur_next = cur_q - DepthW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_sample_q <= 1'b0;
      lat_q         <= '0;
      jit_q         <= '0;
      depth_q       <= '0;
    end else begin
      if (cmd_i.load && !have_sample_q) begin
        lat_q <= sample_in;
        jit_q <= '0;
      end
      if (cmd_i.lat_wr) begin
        lat_q <= lat_acc[39:16];
      end
      if (cmd_i.jit_wr) begin
        jit_q <= jit_acc[39:16];
      end
      if (cmd_i.commit) begin
        have_sample_q <= 1'b1;
        depth_q       <= cur_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      server_q   <= sender_stamp_i;
      applied_q  <= applied_in;
      buffered_q <= buffered_present_i;
      samp_q     <= sample_in;
      cur_q      <= cur_in;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.meas_wr) begin
      meas_q <= meas_d;
    end
    if (cmd_i.tgt_wr) begin
      target_q <= tgt_d;
    end
    if (cmd_i.commit) begin
      lat_out_q  <= lat_q;
      jit_out_q  <= jit_q;
      tgt_out_q  <= FramesOutW'(target_q);
      meas_out_q <= (|meas_q[31:16]) ? '1 : meas_q[MeasW-1:0];
      cur_out_q  <= FramesOutW'(cur_next);
      dil_out_q  <= dil_d;
    end
  end

  assign latency_out_o     = lat_out_q;
  assign jitter_out_o      = jit_out_q;
  assign target_frames_o   = tgt_out_q;
  assign measured_frames_o = meas_out_q;
  assign current_frames_o  = cur_out_q;
  assign rate_factor_o     = dil_out_q;

endmodule

// ===== rtl/core/adaptive_playout_delay_control.sv =====
// Adaptive playout delay control. An accepted item passes the states LAT, JIT, JUPD,
// WANT, TGT, DIL, DONE; the first item after reset skips to WANT (no averaging pass).
// A new item is taken after the last commit. The four products (two for the first) go
// in turn through one shared 25x18 multiplier. Results wait in an output register.
// Reset clears the averages, the sample flag and the depth, and loads register
// defaults; there is no clearing pass.
module adaptive_playout_delay_control #(
  parameter int unsigned CAPACITY_FRAMES = apdc_pkg::CAPACITY_FRAMES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  apdc_in_if.sink                       pkt_i,
  apdc_out_if.source                    res_o,
  input  logic                          cfg_we_i,
  input  logic [apdc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [apdc_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import apdc_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  apdc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  apdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pkt_i.valid),
    .in_ready_o  (pkt_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  apdc_dp #(
    .CAPACITY_FRAMES (CAPACITY_FRAMES)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_i              (cfg),
    .sender_stamp_i     (pkt_i.sender_stamp),
    .arrival_frame_i    (pkt_i.arrival_frame),
    .play_frame_i       (pkt_i.play_frame),
    .buffered_present_i (pkt_i.buffered_present),
    .latency_out_o      (res_o.latency_out),
    .jitter_out_o       (res_o.jitter_out),
    .target_frames_o    (res_o.target_frames),
    .measured_frames_o  (res_o.measured_frames),
    .current_frames_o   (res_o.current_frames),
    .rate_factor_o      (res_o.rate_factor)
  );

endmodule

// ===== test/apdc_playout_checker.sv =====
// Scoreboard for the adaptive playout delay core: watches the packet, result and
// register-write ports, predicts every result and compares it field by field.
// Depends on apdc_pkg and the apdc_in_if / apdc_out_if channels.
`timescale 1ns / 1ps

module apdc_playout_checker
  import apdc_pkg::*;
#(
  parameter int unsigned CapacityFrames = CAPACITY_FRAMES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  apdc_in_if                  pkt,
  apdc_out_if                 res,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int unsigned         mismatches,
  output int unsigned         outstanding
);

  localparam int unsigned MaxDepth = CapacityFrames - 1;

  typedef struct packed {
    logic [AvgW-1:0]       latency;
    logic [AvgW-1:0]       jitter;
    logic [FramesOutW-1:0] target;
    logic [MeasW-1:0]      measured;
    logic [FramesOutW-1:0] current;
    logic [DilW-1:0]       dilation;
  } playout_res_t;

  cfg_t         regs;
  logic         have_sample;
  logic [23:0]  latency_q;
  logic [23:0]  jitter_q;
  logic [31:0]  depth_q;
  playout_res_t pending_results[$];
  int unsigned  err_count;

  function automatic logic [23:0] smooth(logic [23:0] avg, logic [23:0] x, logic [16:0] s);
    logic [63:0] acc;
    acc = 64'(avg) * (64'd65536 - 64'(s)) + 64'(x) * 64'(s) + 64'd32768;
    return acc[39:16];
  endfunction

  // Advances the model state by one packet and returns the result it causes.
  function automatic playout_res_t predict_playout(logic [31:0] srv, logic [31:0] rcv,
                                                   logic [31:0] ply, logic buffered);
    logic [16:0]  s;
    logic [31:0]  diff, applied, meas, cur;
    logic [23:0]  samp, prev, dev;
    logic [63:0]  wanted, tgt;
    longint       err, dil;
    playout_res_t r;
    s    = (regs.smoothing > SmoothOne) ? SmoothOne : regs.smoothing;
    diff = (rcv >= srv) ? rcv - srv : 32'd0;
    samp = (diff > 32'd65535) ? 24'hFFFFFF : {diff[15:0], 8'd0};
    if (!have_sample) begin
      cur       = (regs.start_frames > MaxDepth) ? MaxDepth : 32'(regs.start_frames);
      latency_q = samp;
      jitter_q  = '0;
    end else begin
      prev      = latency_q;
      dev       = (samp >= prev) ? samp - prev : prev - samp;
      cur       = depth_q;
      latency_q = smooth(prev, samp, s);
      jitter_q  = smooth(jitter_q, dev, s);
    end
    have_sample = 1'b1;

    wanted = (64'(latency_q) << 8) + 64'(regs.jitter_multiplier) * 64'(jitter_q);
    tgt    = (wanted + 64'hFFFF) >> 16;
    if (tgt < 64'(regs.min_frames)) tgt = 64'(regs.min_frames);
    if (tgt > 64'(MaxDepth)) tgt = 64'(MaxDepth);

    applied = (ply >= cur) ? ply - cur : 32'd0;
    meas    = (srv >= applied) ? srv - applied : 32'd0;

    dil = longint'(DilOne);
    if (regs.auto_enable && buffered) begin
      err = longint'(meas) - longint'(tgt);
      dil = 4096 + err * longint'(regs.dilation_gain) * 16;
      if (dil < longint'(regs.dilation_min)) dil = longint'(regs.dilation_min);
      if (dil > longint'(regs.dilation_max)) dil = longint'(regs.dilation_max);
      if (64'(cur) < tgt && meas >= cur) cur = cur + 32'd1;
      else if (64'(cur) > tgt && meas <= cur) cur = cur - 32'd1;
    end
    depth_q = cur;

    r.latency  = latency_q;
    r.jitter   = jitter_q;
    r.target   = tgt[FramesOutW-1:0];
    r.measured = (meas > 32'd65535) ? 16'hFFFF : meas[15:0];
    r.current  = cur[FramesOutW-1:0];
    r.dilation = dil[DilW-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    playout_res_t want;
    if (!rst_ni) begin
      regs        = CfgReset;
      have_sample = 1'b0;
      latency_q   = '0;
      jitter_q    = '0;
      depth_q     = '0;
      err_count   = 0;
      pending_results.delete();
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_SMOOTHING:    regs.smoothing         = cfg_wdata_i[16:0];
          REG_JITTER_MULT:  regs.jitter_multiplier = cfg_wdata_i[15:0];
          REG_MIN_FRAMES:   regs.min_frames        = cfg_wdata_i[5:0];
          REG_DIL_MIN:      regs.dilation_min      = cfg_wdata_i[12:0];
          REG_DIL_MAX:      regs.dilation_max      = cfg_wdata_i[15:0];
          REG_DIL_GAIN:     regs.dilation_gain     = cfg_wdata_i[15:0];
          REG_AUTO_ENABLE:  regs.auto_enable       = cfg_wdata_i[0];
          REG_START_FRAMES: regs.start_frames      = cfg_wdata_i[5:0];
          default: ;
        endcase
      end

      if (res.valid && res.ready) begin
        if (pending_results.size() == 0) begin
          err_count++;
          $display("%0t: result with none expected, actual latency %0d current %0d",
                   $time, res.latency_out, res.current_frames);
        end else begin
          want = pending_results.pop_front();
          check_field("latency_out", 32'(want.latency), 32'(res.latency_out));
          check_field("jitter_out", 32'(want.jitter), 32'(res.jitter_out));
          check_field("target_frames", 32'(want.target), 32'(res.target_frames));
          check_field("measured_frames", 32'(want.measured), 32'(res.measured_frames));
          check_field("current_frames", 32'(want.current), 32'(res.current_frames));
          check_field("rate_factor", 32'(want.dilation), 32'(res.rate_factor));
        end
      end

      if (pkt.valid && pkt.ready)
        pending_results.insert(pending_results.size(),
                               predict_playout(pkt.sender_stamp, pkt.arrival_frame,
                                               pkt.play_frame, pkt.buffered_present));

      mismatches  <= err_count;
      outstanding <= pending_results.size();
    end
  end

endmodule

// ===== test/tb_adaptive_playout_delay_control.sv =====
// Top of the playout delay testbench: clock, reset, packet and register stimulus,
// result back-pressure and the verdict. Depends on apdc_pkg, the channel
// interfaces, adaptive_playout_delay_control and apdc_playout_checker.
`timescale 1ns / 1ps

module tb_adaptive_playout_delay_control;
  import apdc_pkg::*;

  typedef struct packed {
    logic [31:0] srv;
    logic [31:0] rcv;
    logic [31:0] ply;
    logic        buffered;
  } packet_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  int unsigned         mismatches;
  int unsigned         outstanding;
  logic                squeeze_req;

  logic [31:0] strm_srv;
  int unsigned lat_base;
  int unsigned jit_amp;
  int unsigned burst_left;

  apdc_in_if  pkt ();
  apdc_out_if res ();

  adaptive_playout_delay_control u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pkt_i      (pkt),
    .res_o      (res),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  apdc_playout_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pkt        (pkt),
    .res        (res),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(64'd12 * 64'd400_000);
    $display("FAILURE");
    $finish;
  end

  // Result side: stall rate redrawn for each phase of random length; one long hold-off on request.
  initial begin : receiver
    int unsigned stall_pct;
    int unsigned phase_left;
    int unsigned hold_left;
    bit          squeezed;
    stall_pct  = 0;
    phase_left = 0;
    hold_left  = 0;
    squeezed   = 1'b0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (squeeze_req && !squeezed) begin
        squeezed  = 1'b1;
        hold_left = 400;
      end
      if (phase_left == 0) begin
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2: stall_pct = 25;
          3: stall_pct = 50;
          default: stall_pct = 85;
        endcase
        phase_left = $urandom_range(16, 120);
      end
      phase_left--;
      if (hold_left != 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic send_packet(packet_t p);
    pkt.valid            <= 1'b1;
    pkt.sender_stamp     <= p.srv;
    pkt.arrival_frame    <= p.rcv;
    pkt.play_frame       <= p.ply;
    pkt.buffered_present <= p.buffered;
    do @(posedge clk_i); while (!pkt.ready);
    if (burst_left <= 1) begin
      pkt.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 20);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    pkt.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic apply_cfg(cfg_t c);
    reg_idx_e r;
    r = r.first();
    do begin
      cfg_we_i  <= 1'b1;
      cfg_idx_i <= r;
      case (r)
        REG_SMOOTHING:    cfg_wdata_i <= CfgDataW'(c.smoothing);
        REG_JITTER_MULT:  cfg_wdata_i <= CfgDataW'(c.jitter_multiplier);
        REG_MIN_FRAMES:   cfg_wdata_i <= CfgDataW'(c.min_frames);
        REG_DIL_MIN:      cfg_wdata_i <= CfgDataW'(c.dilation_min);
        REG_DIL_MAX:      cfg_wdata_i <= CfgDataW'(c.dilation_max);
        REG_DIL_GAIN:     cfg_wdata_i <= CfgDataW'(c.dilation_gain);
        REG_AUTO_ENABLE:  cfg_wdata_i <= CfgDataW'(c.auto_enable);
        REG_START_FRAMES: cfg_wdata_i <= CfgDataW'(c.start_frames);
        default: ;
      endcase
      @(posedge clk_i);
      r = r.next();
    end while (r != r.first());
    cfg_we_i <= 1'b0;
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    case ($urandom_range(0, 9))
      0: c.smoothing = 17'd1;
      1: c.smoothing = SmoothOne;
      2: c.smoothing = 17'($urandom_range(65537, 131071));
      3: c.smoothing = 17'd0;
      default: c.smoothing = 17'($urandom_range(1000, 40000));
    endcase
    c.jitter_multiplier = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 1024));
    c.min_frames   = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 8));
    c.dilation_min = ($urandom_range(0, 4) == 0) ? 13'($urandom)
                                                 : 13'($urandom_range(1, 4096));
    c.dilation_max = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(4096, 65535));
    c.dilation_gain = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 64));
    c.auto_enable  = ($urandom_range(0, 4) != 0);
    c.start_frames = 6'($urandom);
    return c;
  endfunction

  // Mostly a steady stream with jittered arrival; the rest is noise and broken timing.
  function automatic packet_t random_packet();
    packet_t     p;
    int unsigned kind;
    kind     = $urandom_range(0, 99);
    strm_srv = strm_srv + 32'($urandom_range(0, 3));
    p.srv      = strm_srv;
    p.rcv      = strm_srv + lat_base + $urandom_range(0, jit_amp);
    p.ply      = strm_srv - $urandom_range(0, 70);
    p.buffered = ($urandom_range(0, 7) != 0);
    if (kind < 10) begin
      p.srv      = $urandom;
      p.rcv      = $urandom;
      p.ply      = $urandom;
      p.buffered = 1'($urandom_range(0, 1));
    end else if (kind < 14) begin
      p.rcv = p.srv - $urandom_range(1, 100);
    end else if (kind < 17) begin
      p.rcv = p.srv + $urandom_range(65535, 200000);
    end else if (kind < 20) begin
      p.ply = $urandom_range(0, 70);
    end else if (kind < 22) begin
      p.ply = p.srv + $urandom_range(100, 100000);
    end else if (kind < 24) begin
      p.ply = p.srv - $urandom_range(65536, 1000000);
    end
    return p;
  endfunction

  initial begin : stimulus
    int unsigned wait_cycles;
    pkt.valid            <= 1'b0;
    pkt.sender_stamp     <= '0;
    pkt.arrival_frame    <= '0;
    pkt.play_frame       <= '0;
    pkt.buffered_present <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= REG_SMOOTHING;
    cfg_wdata_i          <= '0;
    squeeze_req          <= 1'b0;
    rst_ni               <= 1'b0;
    burst_left = 4;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // start depth only matters before the first sample; other registers keep defaults
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_START_FRAMES;
    cfg_wdata_i <= 17'd63;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;

    send_packet('{32'd100, 32'd105, 32'd103, 1'b1});
    send_packet('{32'd0, 32'd0, 32'd0, 1'b0});
    send_packet('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1});
    send_packet('{32'hFFFF_FFFF, 32'd0, 32'd0, 1'b1});
    send_packet('{32'd0, 32'hFFFF_FFFF, 32'd0, 1'b1});
    send_packet('{32'd0, 32'd65535, 32'd0, 1'b1});
    send_packet('{32'd0, 32'd65536, 32'hFFFF_FFFF, 1'b1});
    send_packet('{32'h0020_0000, 32'h0020_0004, 32'd5, 1'b1});
    send_packet('{32'd1000, 32'd1003, 32'd995, 1'b1});
    send_packet('{32'd1001, 32'd1004, 32'd996, 1'b0});

    // zero smoothing, widest dilation range, heavy jitter weight
    drain();
    apply_cfg('{17'd0, 16'd65535, 6'd63, 13'd1, 16'd65535, 16'd65535, 1'b1, 6'd0});
    send_packet('{32'd2000, 32'd2002, 32'd1990, 1'b1});
    send_packet('{32'd2001, 32'd2010, 32'd1995, 1'b1});
    send_packet('{32'd2002, 32'd2002, 32'd2002, 1'b1});
    send_packet('{32'd5, 32'd3, 32'd10000, 1'b1});

    // smoothing above one, crossed dilation limits
    drain();
    apply_cfg('{17'h1FFFF, 16'd0, 6'd0, 13'h1FFF, 16'd4096, 16'd1, 1'b1, 6'd7});
    send_packet('{32'd3000, 32'd3004, 32'd2995, 1'b1});
    send_packet('{32'd3001, 32'd3001, 32'd2999, 1'b1});
    send_packet('{32'd3002, 32'd3010, 32'd2990, 1'b1});

    // automatic mode off
    drain();
    apply_cfg('{SmoothOne, 16'd256, 6'd5, 13'd4096, 16'd4096, 16'd300, 1'b0, 6'd2});
    send_packet('{32'd4000, 32'd4003, 32'd3990, 1'b1});
    send_packet('{32'd4001, 32'd4006, 32'd3995, 1'b0});

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      apply_cfg(random_cfg());
      if (ph == 1) squeeze_req <= 1'b1;
      strm_srv = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 200)
                                             : $urandom;
      lat_base = $urandom_range(0, 40);
      jit_amp  = $urandom_range(0, 20);
      for (int n = 0; n < 142; n++) send_packet(random_packet());
    end

    pkt.valid <= 1'b0;
    wait_cycles = 0;
    do begin
      @(posedge clk_i);
      wait_cycles++;
    end while (outstanding != 0 && wait_cycles < 20000);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/apdc_pkg.sv
rtl/core/apdc_if.sv
rtl/core/apdc_cfg.sv
rtl/core/apdc_ctrl.sv
rtl/core/apdc_dp.sv
rtl/core/adaptive_playout_delay_control.sv
test/apdc_playout_checker.sv
test/tb_adaptive_playout_delay_control.sv
